FILE: hw/rtl/ilsu_pkg.sv
// Package: word types, command and status codes for the indexed list store.
package ilsu_pkg;

    localparam int POS_W  = 9;
    localparam int DATA_W = 32;
    localparam int CNT_OUT_W = 9;

    localparam logic [2:0] CMD_READ       = 3'd0;
    localparam logic [2:0] CMD_INS_HEAD   = 3'd1;
    localparam logic [2:0] CMD_INS_TAIL   = 3'd2;
    localparam logic [2:0] CMD_INS_AT     = 3'd3;
    localparam logic [2:0] CMD_DELETE     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [CNT_OUT_W-1:0]     count;
    } rsp_word_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/ilsu_cell.sv
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
module ilsu_cell #(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  logic                            clk,
    input  ilsu_pkg::cell_ctl_t             ctl,
    input  logic [IDX_W-1:0]                sel_pos,
    input  logic signed [ilsu_pkg::DATA_W-1:0] left_data,
    input  logic signed [ilsu_pkg::DATA_W-1:0] right_data,
    output logic signed [ilsu_pkg::DATA_W-1:0] data,
    output logic signed [ilsu_pkg::DATA_W-1:0] rd_data
);
    import ilsu_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit;
    logic                     above;

    assign hit   = (sel_pos == MY_IDX);
    assign above = (MY_IDX > sel_pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (hit)
                data_next = ctl.value;
            else if (above)
                data_next = left_data;
        end
        else if (ctl.del)
        begin
            if (hit || above)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

FILE: hw/rtl/indexed_list_store_unit.sv
// Top level of the indexed list store: request stage, cell chain, response register.
//
//  channel | signals                    | word
//  --------+----------------------------+----------------------------------
//  request | req_valid, req_ready, req  | command, position, value
//  result  | rsp_valid, rsp_ready, rsp  | read_value, status, count
//
// A request is taken into a one-word stage, then executed when the result register
// is free or being drained; the stage is blocked until its word executes.
// Execution shifts the whole cell chain at once; a read ORs the hit cell.
// Reset clears the count and handshake state; cell contents stay undefined.
// A stall on the result side holds the stage and the count.
module indexed_list_store_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ilsu_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ilsu_pkg::rsp_word_t rsp
);
    import ilsu_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Request stage
    logic      pend_reg;
    logic      pend_next;
    req_word_t req_reg;

    // Result register
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_word_t rsp_reg;
    rsp_word_t rsp_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             exec;
    logic             full;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             pos_lt_cnt;
    logic             pos_le_cnt;
    logic [IDX_W+POS_W-1:0] pos_wide;
    logic [IDX_W+CNT_W-1:0] cnt_wide;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_out_wide;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_hold_wide;
    logic [CNT_OUT_W-1:0]       cnt_out;

    cell_ctl_t        ctl;
    logic [IDX_W-1:0] sel_pos;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
    logic signed [DATA_W-1:0] rd_or;

    assign req_ready = !pend_reg;
    assign exec      = pend_reg && (!rsp_valid_reg || rsp_ready);

    assign full       = (count_reg == CAP_CNT);
    assign pos_ext    = {{CNT_W{1'b0}}, req_reg.position};
    assign cnt_ext    = {{POS_W{1'b0}}, count_reg};
    assign pos_lt_cnt = (pos_ext < cnt_ext);
    assign pos_le_cnt = (pos_ext <= cnt_ext);
    assign pos_wide   = {{IDX_W{1'b0}}, req_reg.position};
    assign cnt_wide   = {{IDX_W{1'b0}}, count_reg};

    // Decode the pending word into chain control and the result word
    always_comb
    begin
        ctl.ins        = 1'b0;
        ctl.del        = 1'b0;
        ctl.value      = req_reg.value;
        sel_pos        = pos_wide[IDX_W-1:0];
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_next.read_value = '0;
        rsp_next.status     = ST_OK;
        case (req_reg.command)
            CMD_READ:
            begin
                if (pos_lt_cnt)
                    rsp_next.read_value = rd_or;
                else
                begin
                    rsp_next.read_value = '1;
                    rsp_next.status     = ST_RANGE;
                end
            end
            CMD_INS_HEAD:
            begin
                sel_pos = '0;
                if (full)
                    rsp_next.status = ST_FULL;
                else
                    ctl.ins = 1'b1;
            end
            CMD_INS_TAIL:
            begin
                sel_pos = cnt_wide[IDX_W-1:0];
                if (full)
                    rsp_next.status = ST_FULL;
                else
                    ctl.ins = 1'b1;
            end
            CMD_INS_AT:
            begin
                if (!pos_le_cnt)
                    rsp_next.status = ST_RANGE;
                else if (full)
                    rsp_next.status = ST_FULL;
                else
                    ctl.ins = 1'b1;
            end
            CMD_DELETE:
            begin
                if (pos_lt_cnt)
                    ctl.del = 1'b1;
                else
                    rsp_next.status = ST_RANGE;
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
        // Gate the chain until the word actually executes
        if (!exec)
        begin
            ctl.ins = 1'b0;
            ctl.del = 1'b0;
        end
        if (ctl.ins)
            count_next = count_reg + 1'b1;
        else if (ctl.del)
            count_next = count_reg - 1'b1;
        cnt_out_wide   = {{CNT_OUT_W{1'b0}}, count_next};
        rsp_next.count = cnt_out_wide[CNT_OUT_W-1:0];
    end

    // Read bus: only the addressed cell drives nonzero data
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | cell_rd[i];
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;
        if (g == 0)
        begin : g_first
            assign left_d = req_reg.value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        ilsu_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .sel_pos    (sel_pos),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .rd_data    (cell_rd[g])
        );
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (req_valid && req_ready)
            pend_next = 1'b1;
        else if (exec)
            pend_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (exec)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers: request word loads on accept, result word on execute, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (exec)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Stored count as it stands until the next word executes
    assign cnt_hold_wide = {{CNT_OUT_W{1'b0}}, count_reg};
    assign cnt_out       = cnt_hold_wide[CNT_OUT_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.count == cnt_out))
        else $error("reported count differs from stored count");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && rsp_next.status == ST_FULL) |-> full)
        else $error("full status while store not full");
`endif

endmodule

FILE: tb/indexed_list_store_unit_tb.sv
// Testbench for the indexed list store: directed and random request words checked by a scoreboard.
module indexed_list_store_unit_tb;

    import ilsu_pkg::*;

    localparam int DEPTH      = 256;
    localparam int N_RANDOM   = 1880;
    localparam int HOLD_OFF   = 300;
    localparam int DRAIN_WAIT = 20;

    // Command codes the block decodes as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    // Scoreboard: shadow copy of the list plus the queue of results still owed
    class list_scoreboard #(int CELLS = 256);
        logic signed [31:0] cells [CELLS];
        int unsigned        stored;
        rsp_word_t          owed [$];
        int                 errors;
        int                 checked;

        function new();
            stored  = 0;
            errors  = 0;
            checked = 0;
        endfunction

        // Open a slot at pos, push later entries up by one
        function void shift_in(int unsigned pos, logic signed [31:0] v);
            for (int unsigned i = stored; i > pos; i--)
                cells[i] = cells[i - 1];
            cells[pos] = v;
            stored++;
        endfunction

        // Apply one accepted request to the shadow list and queue its result
        function void note_request(req_word_t w);
            rsp_word_t e;
            e.read_value = '0;
            e.status     = ST_OK;
            case (w.command)
                CMD_READ:
                    if (w.position < stored)
                        e.read_value = cells[w.position];
                    else
                    begin
                        e.read_value = -32'sd1;
                        e.status     = ST_RANGE;
                    end
                CMD_INS_HEAD:
                    if (stored >= CELLS)
                        e.status = ST_FULL;
                    else
                        shift_in(0, w.value);
                CMD_INS_TAIL:
                    if (stored >= CELLS)
                        e.status = ST_FULL;
                    else
                        shift_in(stored, w.value);
                CMD_INS_AT:
                    if (w.position > stored)
                        e.status = ST_RANGE;
                    else if (stored >= CELLS)
                        e.status = ST_FULL;
                    else
                        shift_in(w.position, w.value);
                CMD_DELETE:
                    if (w.position < stored)
                    begin
                        for (int unsigned i = w.position; i + 1 < stored; i++)
                            cells[i] = cells[i + 1];
                        stored--;
                    end
                    else
                        e.status = ST_RANGE;
                default:
                    ;
            endcase
            e.count = stored[8:0];
            owed.push_back(e);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
        endtask

        task check_result(rsp_word_t r);
            rsp_word_t e;
            if (owed.size() == 0)
                report_mismatch("unexpected result, count", r.count, -1);
            else
            begin
                e = owed.pop_front();
                if (r.read_value !== e.read_value)
                    report_mismatch("read_value", r.read_value, e.read_value);
                if (r.status !== e.status)
                    report_mismatch("status", r.status, e.status);
                if (r.count !== e.count)
                    report_mismatch("count", r.count, e.count);
            end
            checked++;
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp;

    list_scoreboard #(DEPTH) sb;

    indexed_list_store_unit #(
        .CAPACITY (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offer one word and hold it until the block takes it; note it at that edge
    task automatic push_word(input req_word_t w);
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(w);
    endtask

    task automatic send(input logic [2:0] c, input logic [8:0] p, input logic [31:0] v);
        req_word_t w;
        w.command  = c;
        w.position = p;
        w.value    = v;
        push_word(w);
    endtask

    // Draw a random request word. The command mix depends on where the run is, so the
    // list fills up to capacity, churns while full, drains, and otherwise stays mixed.
    // Positions lean toward the valid range of the current list.
    function automatic req_word_t pick_word(int idx);
        req_word_t   w;
        int unsigned n;
        int          r;
        int          c_rd, c_hd, c_tl, c_at, c_dl;
        n = sb.stored;
        if (idx >= 250 && idx < 700)
        begin
            // fill
            c_rd = 10; c_hd = 30; c_tl = 55; c_at = 90; c_dl = 97;
        end
        else if (idx >= 700 && idx < 950)
        begin
            // churn near full
            c_rd = 30; c_hd = 45; c_tl = 62; c_at = 80; c_dl = 96;
        end
        else if (idx >= 950 && idx < 1450)
        begin
            // drain
            c_rd = 25; c_hd = 29; c_tl = 33; c_at = 37; c_dl = 97;
        end
        else
        begin
            c_rd = 35; c_hd = 47; c_tl = 59; c_at = 73; c_dl = 95;
        end
        r = $urandom_range(0, 99);
        if (r < c_rd)
            w.command = CMD_READ;
        else if (r < c_hd)
            w.command = CMD_INS_HEAD;
        else if (r < c_tl)
            w.command = CMD_INS_TAIL;
        else if (r < c_at)
            w.command = CMD_INS_AT;
        else if (r < c_dl)
            w.command = CMD_DELETE;
        else
            w.command = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));

        case ($urandom_range(0, 9))
            0: w.position = 9'($urandom_range(0, 511));
            1:
                case ($urandom_range(0, 3))
                    0: w.position = '0;
                    1: w.position = 9'(n);
                    2: w.position = (n > 0) ? 9'(n - 1) : '0;
                    default: w.position = '1;
                endcase
            default: w.position = 9'($urandom_range(0, n));
        endcase

        if ($urandom_range(0, 15) == 0)
            case ($urandom_range(0, 3))
                0: w.value = 32'sh8000_0000;
                1: w.value = 32'sh7FFF_FFFF;
                2: w.value = '0;
                default: w.value = '1;
            endcase
        else
            w.value = $urandom;
        return w;
    endfunction

    // Check every result word the moment it is taken
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            sb.check_result(rsp);
    end

    // Result side: stall on segments of varying pattern; on one segment hold off long
    // enough that the block backs up and stops taking request words.
    initial
    begin
        int seg_len;
        int mode;
        int seg_no;
        seg_no = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (seg_no == 4)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                seg_len = $urandom_range(20, 200);
                mode    = $urandom_range(0, 3);
                for (int i = 0; i < seg_len; i++)
                begin
                    case (mode)
                        0: rsp_ready <= 1'b1;
                        1: rsp_ready <= ($urandom_range(0, 3) != 0);
                        2: rsp_ready <= (i % 3 != 2);
                        default: rsp_ready <= $urandom_range(0, 1);
                    endcase
                    @(posedge clk);
                end
            end
            seg_no++;
        end
    end

    // Hard stop if the block hangs
    initial
    begin
        #(4 * 600000);
        $display("indexed_list_store_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        int sent;
        int burst;
        int gap;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store errors, extremes, every command, appends and bad positions
        send(CMD_READ,     9'd0,   32'd0);
        send(CMD_READ,     9'd511, 32'd0);
        send(CMD_DELETE,   9'd0,   32'd0);
        send(CMD_INS_AT,   9'd1,   32'h1111_1111);
        send(CMD_INS_AT,   9'd0,   32'h8000_0000);
        send(CMD_INS_HEAD, 9'd511, 32'h7FFF_FFFF);
        send(CMD_INS_TAIL, 9'd0,   32'hFFFF_FFFF);
        send(CMD_INS_AT,   9'd3,   32'h0000_0000);
        send(CMD_INS_AT,   9'd2,   32'h1234_5678);
        send(CMD_INS_AT,   9'd6,   32'hDEAD_BEEF);
        send(CMD_READ,     9'd0,   32'hFFFF_FFFF);
        send(CMD_READ,     9'd4,   32'd0);
        send(CMD_READ,     9'd5,   32'd0);
        send(CMD_READ,     9'd511, 32'd0);
        send(CMD_SPARE_A,  9'd0,   32'h5555_5555);
        send(CMD_SPARE_B,  9'd511, 32'hFFFF_FFFF);
        send(CMD_SPARE_C,  9'd2,   32'hAAAA_AAAA);
        send(CMD_DELETE,   9'd5,   32'd0);
        send(CMD_DELETE,   9'd4,   32'd0);
        send(CMD_DELETE,   9'd0,   32'd0);
        send(CMD_DELETE,   9'd511, 32'd0);
        send(CMD_READ,     9'd1,   32'd0);
        send(CMD_INS_AT,   9'd511, 32'h0F0F_0F0F);

        // Random: bursts of back-to-back words with random gaps in between
        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                push_word(pick_word(sent));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b0;

        // Drain, then give stray results a chance to show up
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("indexed_list_store_unit_tb: done, clean");
        else
            $display("indexed_list_store_unit_tb: done, errors");
        $finish;
    end

endmodule
